// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands used by the u8h_checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/u8h_pkg.sv =====
// ----------------------------------------------------------------------------
// u8h_pkg
// types and constants of the utf-8 code point hash
// ----------------------------------------------------------------------------
package u8h_pkg;

  localparam int unsigned HashW = 32;
  localparam int unsigned CpW   = 21;

  localparam logic [HashW-1:0] HASH_SEED   = 32'd5381;
  localparam logic [5:0]       CONT_MASK   = 6'h3F;
  localparam logic [7:0]       ASCII_LIMIT = 8'h80;

  // number of continuation bytes still expected
  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_ONE   = 2'd1,
    PEND_TWO   = 2'd2,
    PEND_THREE = 2'd3
  } u8h_pend_e;

  typedef struct packed {
    logic [HashW-1:0] hash;
    logic [CpW-1:0]   partial;
    u8h_pend_e        pending;
    logic             err;
  } u8h_state_t;

  localparam u8h_state_t STATE_RESET = '{
    hash:    HASH_SEED,
    partial: '0,
    pending: PEND_NONE,
    err:     1'b0
  };

endpackage

// ===== rtl/u8h_decode.sv =====
// ----------------------------------------------------------------------------
// u8h_decode
// one-byte step of the utf-8 decoder and hash update
// ----------------------------------------------------------------------------
module u8h_decode (
  input  u8h_pkg::u8h_state_t state_i,
  input  logic [7:0]          data_byte_i,
  input  logic                no_byte_i,
  output u8h_pkg::u8h_state_t state_o
);
  import u8h_pkg::*;

  logic [CpW-1:0]   cp;
  logic             absorb;
  logic [CpW-1:0]   shifted;
  logic [HashW-1:0] hash_x33;

  // h * 33 as shift and add
  assign hash_x33 = {state_i.hash[HashW-6:0], 5'b0} + state_i.hash;
  assign shifted  = {state_i.partial[CpW-7:0], data_byte_i[5:0] & CONT_MASK};

  always_comb begin
    state_o = state_i;
    cp      = '0;
    absorb  = 1'b0;
    if (!no_byte_i) begin
      if (state_i.pending != PEND_NONE) begin
        state_o.pending = u8h_pend_e'(state_i.pending - 2'd1);
        if (state_i.pending == PEND_ONE) begin
          cp              = shifted;
          absorb          = 1'b1;
          state_o.partial = '0;
        end else begin
          state_o.partial = shifted;
        end
      end else if (data_byte_i < ASCII_LIMIT) begin
        cp     = CpW'(data_byte_i);
        absorb = 1'b1;
      end else if (!data_byte_i[5]) begin
        state_o.partial = CpW'(data_byte_i[4:0]);
        state_o.pending = PEND_ONE;
      end else if (!data_byte_i[4]) begin
        state_o.partial = CpW'(data_byte_i[3:0]);
        state_o.pending = PEND_TWO;
      end else begin
        // lead of 0xf8 and above decodes as a four-byte lead but is flagged
        state_o.err     = state_i.err | data_byte_i[3];
        state_o.partial = CpW'(data_byte_i[2:0]);
        state_o.pending = PEND_THREE;
      end
    end
    if (absorb) begin
      state_o.hash = hash_x33 ^ HashW'(cp);
    end
  end

endmodule

// ===== rtl/utf8_codepoint_hash.sv =====
// ----------------------------------------------------------------------------
// utf8_codepoint_hash
// djb2a-style hash (h*33 xor code point) over the code points of a utf-8 string
// ----------------------------------------------------------------------------
// path: a last word goes from the input register through the decode/hash step into the result register
// throughput: one input word per cycle, set by the combinational decode/hash step
// only a last word waits on a stalled result; other words keep flowing
// reset: asynchronous, active low; hash state returns to seed 5381, both stages empty
module utf8_codepoint_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input word channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_string_i,
  input  logic        no_byte_i,
  // result word channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] hash_value_o,
  output logic        bad_encoding_o
);
  import u8h_pkg::*;

  // input register
  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       eos_q;
  logic       nob_q;

  // decoder state carried from one word to the next
  u8h_state_t state_q, state_d;
  u8h_state_t step_state;

  // result register
  logic             out_valid_q;
  logic [HashW-1:0] hash_q;
  logic             bad_q;

  logic out_free;
  logic advance;
  logic in_accept;

  // the result register can take a new word when empty or being drained
  assign out_free   = !out_valid_q || !out_stall_i;
  // a last word needs room in the result register, other words never wait
  assign advance    = in_valid_q && (out_free || !eos_q);
  assign in_stall_o = in_valid_q && eos_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  u8h_decode u_decode (
    .state_i     (state_q),
    .data_byte_i (byte_q),
    .no_byte_i   (nob_q),
    .state_o     (step_state)
  );

  // last word of a string restarts the state for the next string
  always_comb begin
    state_d = state_q;
    if (advance) begin
      state_d = eos_q ? STATE_RESET : step_state;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // payload of the input register, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q <= data_byte_i;
      eos_q  <= end_of_string_i;
      nob_q  <= no_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RESET;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && eos_q;
    end
  end

  // result payload: hash over completed code points, error if mid-sequence or after a lead of 0xf8 and up
  always_ff @(posedge clk_i) begin
    if (advance && eos_q) begin
      hash_q <= step_state.hash;
      bad_q  <= step_state.err | (step_state.pending != PEND_NONE);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hash_value_o   = hash_q;
  assign bad_encoding_o = bad_q;

endmodule

// ===== rtl/u8h_checker.sv =====
// ----------------------------------------------------------------------------
// u8h_checker
// port-level assertions for utf8_codepoint_hash, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module u8h_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        end_of_string_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] hash_value_o,
  input logic        bad_encoding_o
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] open_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // strings accepted whose result word is not yet taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 2'd0;
    end else begin
      open_q <= open_q + 2'(in_acc && end_of_string_i) - 2'(out_acc);
    end
  end

  `ASSERT_SAME(a_no_invented, clk_i, rst_ni, out_acc, open_q != 2'd0, "result word without a string")
  `ASSERT_SAME(a_open_bound, clk_i, rst_ni, 1'b1, open_q != 2'd3, "more strings in flight than stages")
  `ASSERT_SAME(a_empty_out_no_stall, clk_i, rst_ni, !out_valid_o, !in_stall_o, "stall with empty result")
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(hash_value_o) && $stable(bad_encoding_o), "stalled result changed")

endmodule

bind utf8_codepoint_hash u8h_checker u_u8h_checker (.*);

// ===== bench/utf8_hash_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_hash_checker
// watches both word channels of the utf-8 code point hash, keeps its own
// decode and hash state, and compares every result word with the prediction
// ----------------------------------------------------------------------------
module utf8_hash_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_string_i,
  input  logic        no_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] hash_value_i,
  input  logic        bad_encoding_i,
  output int          mismatch_count_o,
  output int          awaiting_o
);
  import u8h_pkg::*;

  typedef struct packed {
    logic [HashW-1:0] hash;
    logic             bad;
  } digest_t;

  u8h_state_t decode_q;
  digest_t    expected_digests[$];
  int         mismatches = 0;
  int         awaiting_q = 0;

  assign mismatch_count_o = mismatches;
  assign awaiting_o       = awaiting_q;

  // h*33 xor code point, wrapping at 32 bits
  function automatic logic [HashW-1:0] mix_cp(logic [HashW-1:0] h, logic [CpW-1:0] cp);
    return ((h << 5) + h) ^ HashW'(cp);
  endfunction

  function automatic u8h_state_t fold_byte(u8h_state_t s, logic [7:0] b);
    u8h_state_t n;
    n = s;
    if (s.pending != PEND_NONE) begin
      // any byte inside a sequence is taken as a continuation
      n.partial = {s.partial[CpW-7:0], b[5:0] & CONT_MASK};
      n.pending = u8h_pend_e'(s.pending - 2'd1);
      if (n.pending == PEND_NONE) begin
        n.hash    = mix_cp(s.hash, n.partial);
        n.partial = '0;
      end
    end else if (b < ASCII_LIMIT) begin
      n.hash = mix_cp(s.hash, CpW'(b));
    end else if (!b[5]) begin
      n.partial = CpW'(b[4:0]);
      n.pending = PEND_ONE;
    end else if (!b[4]) begin
      n.partial = CpW'(b[3:0]);
      n.pending = PEND_TWO;
    end else begin
      // 0xf8 and up still decode as a four byte lead
      n.err     = s.err | b[3];
      n.partial = CpW'(b[2:0]);
      n.pending = PEND_THREE;
    end
    return n;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t ns mismatch on %s: expected %h, got %h", $time, what, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    digest_t got;
    digest_t want;
    if (!rst_ni) begin
      decode_q = STATE_RESET;
      expected_digests.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{hash: hash_value_i, bad: bad_encoding_i};
        if (expected_digests.size() == 0) begin
          flag_mismatch("unexpected result word, hash", 32'h0, got.hash);
        end else begin
          want = expected_digests.pop_front();
          if (got.hash !== want.hash)
            flag_mismatch("hash_value", want.hash, got.hash);
          if (got.bad !== want.bad)
            flag_mismatch("bad_encoding", 32'(want.bad), 32'(got.bad));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (!no_byte_i)
          decode_q = fold_byte(decode_q, data_byte_i);
        if (end_of_string_i) begin
          want.hash = decode_q.hash;
          want.bad  = decode_q.err | (decode_q.pending != PEND_NONE);
          expected_digests.push_back(want);
          decode_q = STATE_RESET;
        end
      end
    end
    awaiting_q = expected_digests.size();
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// drives utf-8 strings one byte word at a time into the code point hash,
// with random bursts on the input side and random stalls on the result side;
// the checker beside the block predicts and compares every result word
// ----------------------------------------------------------------------------
module tb_top;

  // words of input to send, counting only words that carry a byte or end a string
  localparam int StringWords = 1950;
  // cycles without any accepted word before the run is given up
  localparam int IdleLimit   = 2000;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte       = 8'h00;
  logic        end_of_string   = 1'b0;
  logic        no_byte         = 1'b0;
  logic        out_valid;
  logic        out_stall       = 1'b0;
  logic [31:0] hash_value;
  logic        bad_encoding;

  int          mismatches;
  int          awaiting;
  int          words_sent      = 0;
  int          burst_left      = 0;
  int          idle_cycles     = 0;
  stall_mode_e stall_mode      = STALL_NONE;
  int          stall_left      = 0;
  int          stall_tick      = 0;

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  utf8_codepoint_hash dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .data_byte_i     (data_byte),
    .end_of_string_i (end_of_string),
    .no_byte_i       (no_byte),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .hash_value_o    (hash_value),
    .bad_encoding_o  (bad_encoding)
  );

  utf8_hash_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .data_byte_i      (data_byte),
    .end_of_string_i  (end_of_string),
    .no_byte_i        (no_byte),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .hash_value_i     (hash_value),
    .bad_encoding_i   (bad_encoding),
    .mismatch_count_o (mismatches),
    .awaiting_o       (awaiting)
  );

  // result side: pick a stall pattern, keep it for a random stretch
  always @(negedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(16, 96);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= ((stall_tick % 7) < 3);
    endcase
  end

  // watchdog: any accepted word on either side restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IdleLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one input word; called at a falling edge, returns at a falling edge
  task automatic send_word(input logic [7:0] b, input logic eos, input logic nb);
    int gap;
    if (burst_left == 0) begin
      // about a third of the bursts follow on without a gap
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid      <= 1'b1;
    data_byte     <= b;
    end_of_string <= eos;
    no_byte       <= nb;
    // hold the word until the block takes it
    do @(posedge clk); while (!(in_valid && !in_stall));
    @(negedge clk);
    if (!nb || eos)
      words_sent++;
  endtask

  // pause the input until every result word has come back
  task automatic drain();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (awaiting != 0) @(negedge clk);
  endtask

  // a string of random code points, mostly well formed, some noise
  task automatic send_random_string();
    logic [7:0] str_bytes[$];
    int         n_chars;
    int         kind;
    int         len;
    len     = 0;
    n_chars = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 6);
    for (int i = 0; i < n_chars; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        str_bytes.push_back(8'($urandom_range(0, 127)));
        len = 1;
      end else if (kind < 65) begin
        str_bytes.push_back(8'hC0 | 8'($urandom_range(0, 31)));
        len = 2;
      end else if (kind < 80) begin
        str_bytes.push_back(8'hE0 | 8'($urandom_range(0, 15)));
        len = 3;
      end else if (kind < 93) begin
        // upper half of this range are the illegal 0xf8..0xff leads
        str_bytes.push_back(8'hF0 | 8'($urandom_range(0, 15)));
        len = 4;
      end else begin
        // lone random byte, may swallow the next bytes as continuations
        str_bytes.push_back(8'($urandom_range(0, 255)));
        len = 1;
      end
      for (int k = 1; k < len; k++) begin
        if ($urandom_range(0, 15) == 0)
          str_bytes.push_back(8'($urandom_range(0, 255)));
        else
          str_bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
      end
    end
    // now and then the string stops inside its last sequence
    if (len > 1 && $urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, len - 1)) void'(str_bytes.pop_back());

    if (str_bytes.size() == 0 || $urandom_range(0, 4) == 0) begin
      // close with a separate no-byte word
      foreach (str_bytes[i]) begin
        if ($urandom_range(0, 39) == 0)
          send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        send_word(str_bytes[i], 1'b0, 1'b0);
      end
      send_word(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    end else begin
      foreach (str_bytes[i]) begin
        if ($urandom_range(0, 39) == 0)
          send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        send_word(str_bytes[i], i == str_bytes.size() - 1, 1'b0);
      end
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty string
    send_word(8'h00, 1'b1, 1'b1);
    // a no-byte word in the middle is ignored, its data too
    send_word(8'hFF, 1'b0, 1'b1);
    send_word(8'h41, 1'b1, 1'b0);
    // ascii extremes
    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'h7F, 1'b1, 1'b0);
    // two, three and four byte sequences
    send_word(8'hC3, 1'b0, 1'b0);
    send_word(8'hA9, 1'b1, 1'b0);
    send_word(8'hE2, 1'b0, 1'b0);
    send_word(8'h82, 1'b0, 1'b0);
    send_word(8'hAC, 1'b1, 1'b0);
    send_word(8'hF0, 1'b0, 1'b0);
    send_word(8'h9F, 1'b0, 1'b0);
    send_word(8'h98, 1'b0, 1'b0);
    send_word(8'h80, 1'b1, 1'b0);
    // illegal 0xff lead, still eats three continuations
    send_word(8'hFF, 1'b0, 1'b0);
    send_word(8'hBF, 1'b0, 1'b0);
    send_word(8'hBF, 1'b0, 1'b0);
    send_word(8'hBF, 1'b1, 1'b0);
    // stray continuation acts as a two byte lead, ascii byte completes it
    send_word(8'h80, 1'b0, 1'b0);
    send_word(8'h41, 1'b1, 1'b0);
    // string cut short inside a three byte sequence
    send_word(8'hE2, 1'b0, 1'b0);
    send_word(8'h82, 1'b1, 1'b0);
    // cut short, ended by a no-byte word
    send_word(8'hC3, 1'b0, 1'b0);
    send_word(8'h55, 1'b1, 1'b1);

    drain();

    while (words_sent < StringWords) begin
      send_random_string();
      if ($urandom_range(0, 149) == 0)
        drain();
    end

    // let the last results drain, then idle before the final check
    drain();
    repeat (8) @(negedge clk);

    if (mismatches == 0 && awaiting == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
